/* hdl/pasm_pkg.sv */
// Shared types, field widths and mode codes for the polynomial add, subtract and multiply block.
package pasm_pkg;

  localparam int MAX_DEGREE_DEF = 31;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 5;
  localparam int VALUE_W = 16;
  localparam int POWER_W = 6;
  localparam int COEF_W  = 40;
  localparam int TERM_W  = 2 * VALUE_W;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SUB    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MUL    = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_item_t;

  typedef struct packed {
    logic [POWER_W-1:0]       power;
    logic signed [COEF_W-1:0] coef;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic               wr_a;
    logic               wr_b;
    logic               acc_clr;
    logic               issue;
    op_e                op;
    logic [INDEX_W-1:0] ia;
    logic [INDEX_W-1:0] jb;
    logic               out_load;
    logic [POWER_W-1:0] power;
  } pasm_cmd_t;

  typedef struct packed {
    logic [INDEX_W-1:0] deg_a;
    logic [INDEX_W-1:0] deg_b;
    logic               acc_zero;
    logic               out_busy;
  } pasm_status_t;

endpackage

/* hdl/pasm_ctrl.sv */
// Sequencer that walks result powers and coefficient pairs for each operation item.
module pasm_ctrl import pasm_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  pasm_status_t      status_i,
  output pasm_cmd_t         cmd_o
);

  localparam int IW   = $clog2(MAX_DEGREE + 1);
  localparam int KMAX = 2 * MAX_DEGREE;
  localparam int KW   = $clog2(KMAX + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [KW-1:0]   k_q, k_d;
  logic [IW-1:0]   i_q, i_d;
  logic            found_q, found_d;
  logic [IW-1:0]   deg_a, deg_b;
  logic [IW-1:0]   last_i;
  logic [KW-1:0]   k_next;
  op_e             op_sel;
  logic [KW-1:0]   k_start;

  // First operand index that contributes to power k.
  function automatic logic [IW-1:0] first_i(op_e op, logic [KW-1:0] k, logic [IW-1:0] db);
    logic [KW-1:0] dbx;
    dbx = KW'(db);
    if (op == OP_MUL && k > dbx) begin
      first_i = IW'(k - dbx);
    end else if (op == OP_MUL) begin
      first_i = '0;
    end else begin
      first_i = IW'(k);
    end
  endfunction

  assign deg_a  = status_i.deg_a[IW-1:0];
  assign deg_b  = status_i.deg_b[IW-1:0];
  assign k_next = k_q - KW'(1);
  assign last_i = (op_q == OP_MUL && KW'(deg_a) < k_q) ? deg_a : IW'(k_q);

  assign op_sel  = (mode_i == MODE_MUL) ? OP_MUL : ((mode_i == MODE_SUB) ? OP_SUB : OP_ADD);
  assign k_start = (op_sel == OP_MUL) ? (KW'(deg_a) + KW'(deg_b)) :
                   ((deg_a > deg_b) ? KW'(deg_a) : KW'(deg_b));

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    k_d     = k_q;
    i_d     = i_q;
    found_d = found_q;
    cmd_o   = '0;
    cmd_o.op    = op_q;
    cmd_o.ia    = INDEX_W'(i_q);
    cmd_o.jb    = (op_q == OP_MUL) ? INDEX_W'(IW'(k_q - KW'(i_q))) : INDEX_W'(IW'(k_q));
    cmd_o.power = POWER_W'(k_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i) inside
            MODE_LOAD_A: cmd_o.wr_a = 1'b1;
            MODE_LOAD_B: cmd_o.wr_b = 1'b1;
            [MODE_ADD:MODE_MUL]: begin
              op_d          = op_sel;
              k_d           = k_start;
              i_d           = first_i(op_sel, k_start, deg_b);
              found_d       = 1'b0;
              cmd_o.acc_clr = 1'b1;
              state_d       = S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (i_q == last_i) begin
          state_d = S_DRAIN;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // Leading zero powers above power zero are dropped until the first nonzero one.
        if (!found_q && k_q != '0 && status_i.acc_zero) begin
          k_d           = k_next;
          i_d           = first_i(op_q, k_next, deg_b);
          cmd_o.acc_clr = 1'b1;
          state_d       = S_ISSUE;
        end else if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          found_d        = 1'b1;
          if (k_q == '0) begin
            state_d = S_IDLE;
          end else begin
            k_d           = k_next;
            i_d           = first_i(op_q, k_next, deg_b);
            cmd_o.acc_clr = 1'b1;
            state_d       = S_ISSUE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      k_q     <= '0;
      i_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      k_q     <= k_d;
      i_q     <= i_d;
      found_q <= found_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ISSUE |-> i_q <= last_i)
    else $error("pair index ran past the last contributing coefficient");

  a_power_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> k_q <= KW'(KMAX))
    else $error("result power beyond the largest possible degree");

  a_last_ends_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && cmd_o.out_load && k_q == '0 |=> state_q == S_IDLE)
    else $error("operation did not finish after the power-zero item");
`endif

endmodule

/* hdl/pasm_dp.sv */
// Operand storage, multiply-accumulate datapath and result output register.
module pasm_dp import pasm_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_item_i,
  input  pasm_cmd_t    cmd_i,
  output pasm_status_t status_o,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output out_item_t    out_item_o
);

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int IW    = $clog2(DEPTH);

  logic signed [VALUE_W-1:0] a_q [DEPTH];
  logic signed [VALUE_W-1:0] b_q [DEPTH];
  logic [IW-1:0]             deg_a_q, deg_b_q;
  logic                      wr_ok;
  logic [IW-1:0]             widx;
  logic [IW-1:0]             ia, jb;
  logic signed [VALUE_W-1:0] a_op, b_op;
  logic signed [TERM_W-1:0]  prod;
  logic signed [TERM_W-1:0]  term_d, term_q;
  logic                      term_vld_q;
  logic signed [COEF_W-1:0]  acc_q;
  logic                      out_vld_q;
  out_item_t                 out_q;

  // Loads to powers above the supported degree are dropped.
  assign wr_ok = (in_item_i.index <= INDEX_W'(MAX_DEGREE));
  assign widx  = in_item_i.index[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < DEPTH; n++) begin
        a_q[n] <= '0;
        b_q[n] <= '0;
      end
      deg_a_q <= '0;
      deg_b_q <= '0;
    end else begin
      if (cmd_i.wr_a && wr_ok) begin
        a_q[widx] <= in_item_i.value;
        if (in_item_i.is_last) begin
          deg_a_q <= widx;
        end
      end
      if (cmd_i.wr_b && wr_ok) begin
        b_q[widx] <= in_item_i.value;
        if (in_item_i.is_last) begin
          deg_b_q <= widx;
        end
      end
    end
  end

  assign ia   = cmd_i.ia[IW-1:0];
  assign jb   = cmd_i.jb[IW-1:0];
  assign a_op = (ia <= deg_a_q) ? a_q[ia] : '0;
  assign b_op = (jb <= deg_b_q) ? b_q[jb] : '0;
  assign prod = a_op * b_op;

  always_comb begin
    case (cmd_i.op)
      OP_ADD:  term_d = TERM_W'(a_op) + TERM_W'(b_op);
      OP_SUB:  term_d = TERM_W'(a_op) - TERM_W'(b_op);
      OP_MUL:  term_d = prod;
      default: term_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      term_vld_q <= cmd_i.issue;
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (term_vld_q) begin
        acc_q <= acc_q + COEF_W'(term_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.power <= cmd_i.power;
      out_q.coef  <= acc_q;
      out_q.last  <= (cmd_i.power == '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign status_o.deg_a    = INDEX_W'(deg_a_q);
  assign status_o.deg_b    = INDEX_W'(deg_b_q);
  assign status_o.acc_zero = (acc_q == '0);
  assign status_o.out_busy = out_vld_q && out_stall_i;

`ifndef NO_ASSERTIONS
  a_clr_vs_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_vld_q |-> !cmd_i.acc_clr)
    else $error("accumulator cleared while a term was still arriving");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_vld_q && out_stall_i))
    else $error("result register overwritten while its item was stalled");

  a_bad_load_keeps_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_a || cmd_i.wr_b) && !wr_ok |=> $stable(deg_a_q) && $stable(deg_b_q))
    else $error("out-of-range load changed an operand degree");
`endif

endmodule

/* hdl/polynomial_add_sub_mul.sv */
// Top level of the polynomial add, subtract and multiply block.
//
//   channel | direction | handshake              | item
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (mode, index, value, is_last)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (power, coef, last)
//
// A load item is written from the idle state. An add or subtract makes one pass of the
// single multiply-accumulate unit per result power; a multiply makes one pass per
// coefficient pair. Each result power then goes through a drain and an emit step.
// Output stalls hold the emit step, since each power waits for a free result register.
// Reset clears both operands to zero and both degrees to zero; no clearing pass is needed.
// The input stalls for the whole of an operation; loads are taken back to back.
module polynomial_add_sub_mul import pasm_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  pasm_cmd_t    cmd;
  pasm_status_t status;

  pasm_ctrl #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (in_item_i.mode),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pasm_dp #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
